>>> rtl/sorted_set_table_defines.svh
// ----------------------------------------------------------------------------
// Sorted set table assertion macros
// Shared concurrent assertion forms for the sorted set table modules.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_TABLE_DEFINES_SVH
`define SORTED_SET_TABLE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SST_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked on every clock edge outside reset.
`define SST_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Condition that must be followed by another in the next cycle.
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// Sorted set table package
// Transfer types, operation codes and control types shared by the modules.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam logic [1:0] KIND_QUERY  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    localparam int COUNT_OUT_BITS = 7;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] key;
    } sst_in_t;

    typedef struct packed {
        logic                      success;
        logic                      refused_full;
        logic [COUNT_OUT_BITS-1:0] entry_count;
    } sst_out_t;

    // Per-cycle commands broadcast to every cell of the row.
    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic del_en;
    } sst_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_APPLY = 2'b10
    } sst_state_t;

endpackage

>>> rtl/sst_cell.sv
// ----------------------------------------------------------------------------
// Sorted set table cell
// Holds one key, compares it with the requested key and shifts with its
// neighbors on insert or delete.
// ----------------------------------------------------------------------------
module sst_cell import sst_pkg::*; #(
    parameter int KEY_BITS = 16,
    parameter int CNT_W    = 7,
    parameter int IDX      = 0
) (
    input  logic                aclk,
    input  sst_ctrl_t           ctrl,
    input  logic [CNT_W-1:0]    count,
    input  logic [KEY_BITS-1:0] cmp_key,
    input  logic [KEY_BITS-1:0] ins_key,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic                left_lt,
    input  logic [KEY_BITS-1:0] right_key,
    output logic [KEY_BITS-1:0] key_o,
    output logic                lt_o,
    output logic                eq_o
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                lt_reg;
    logic                eq_reg;
    logic                occupied;

    assign occupied = (count > CNT_W'(IDX));

    // Cells at or above the insert/delete position move; the cell right at
    // the position takes the new key on insert.
    always_comb begin
        key_next = key_reg;
        if (ctrl.ins_en && !lt_reg) begin
            key_next = left_lt ? ins_key : left_key;
        end else if (ctrl.del_en && !lt_reg) begin
            key_next = right_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (ctrl.cmp_en) begin
            lt_reg <= occupied && (key_reg < cmp_key);
            eq_reg <= occupied && (key_reg == cmp_key);
        end
    end

    assign key_o = key_reg;
    assign lt_o  = lt_reg;
    assign eq_o  = eq_reg;

endmodule

>>> rtl/sorted_set_table.sv
// A result is registered at the apply step, which follows its input
// transfer once the output is free (every cell compares at the transfer
// edge itself; the apply edge shifts the row and registers the result).
// A new item is taken only after the apply step of the last one, and a
// stalled result holds the apply step.
// Reset: synchronous, active low; the entry count clears to empty at once
// and the key cells are not cleared, so the block is ready right after reset.
// ----------------------------------------------------------------------------
// Sorted set table
// Ordered set of distinct keys with query, insert and delete operations,
// kept in a row of cells that compare in parallel and shift to neighbors.
// ----------------------------------------------------------------------------
`include "sorted_set_table_defines.svh"

module sorted_set_table import sst_pkg::*; #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sst_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sst_out_t m_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Control state.
    sst_state_t       state_reg;
    sst_state_t       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;

    // Operation held between its transfer and the apply step.
    logic [1:0]          op_kind_reg;
    logic [KEY_BITS-1:0] op_key_reg;
    sst_out_t            m_data_reg;

    // Key taken as its low KEY_BITS bits; zero-extended if KEY_BITS is wider.
    logic [31:0]         key_wide;
    logic [KEY_BITS-1:0] key_in;

    // Cell row.
    logic [KEY_BITS-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_eq;
    sst_ctrl_t           ctrl;

    logic in_fire;
    logic out_free;
    logic apply_fire;
    logic found;
    logic is_full;
    logic ins_do;
    logic ins_refused;
    logic del_do;
    logic op_ok;
    logic [31:0] count_wide;

    assign key_wide = {16'd0, s_data.key};
    assign key_in   = key_wide[KEY_BITS-1:0];

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_fire    = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign apply_fire = (state_reg == ST_APPLY) && out_free;

    // The keys are sorted and distinct, so at most one cell can match; the
    // match sits where the less-than flags end.
    assign found   = |cell_eq;
    assign is_full = (count_reg == CNT_W'(CAPACITY));

    always_comb begin
        ins_do      = 1'b0;
        ins_refused = 1'b0;
        del_do      = 1'b0;
        op_ok       = 1'b0;
        unique case (op_kind_reg)
            KIND_QUERY: begin
                op_ok = found;
            end
            KIND_INSERT: begin
                ins_do      = !found && !is_full;
                ins_refused = !found && is_full;
                op_ok       = ins_do;
            end
            KIND_DELETE: begin
                del_do = found;
                op_ok  = found;
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
    end

    // Cells compare at the input transfer and shift at the apply step.
    assign ctrl.cmp_en = in_fire;
    assign ctrl.ins_en = apply_fire && ins_do;
    assign ctrl.del_en = apply_fire && del_do;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KEY_BITS-1:0] left_key;
        logic                left_lt;
        logic [KEY_BITS-1:0] right_key;

        if (i == 0) begin : g_first
            // Nothing sits left of the first cell, so it counts as below.
            assign left_key = op_key_reg;
            assign left_lt  = 1'b1;
        end else begin : g_inner
            assign left_key = cell_key[i-1];
            assign left_lt  = cell_lt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_key = cell_key[i];
        end else begin : g_body
            assign right_key = cell_key[i+1];
        end

        sst_cell #(
            .KEY_BITS (KEY_BITS),
            .CNT_W    (CNT_W),
            .IDX      (i)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .cmp_key   (key_in),
            .ins_key   (op_key_reg),
            .left_key  (left_key),
            .left_lt   (left_lt),
            .right_key (right_key),
            .key_o     (cell_key[i]),
            .lt_o      (cell_lt[i]),
            .eq_o      (cell_eq[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (ctrl.ins_en) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.del_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    // The reported count is the count after the operation, masked to the output width.
    assign count_wide = 32'(count_next);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (apply_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (apply_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_kind_reg <= s_data.kind;
            op_key_reg  <= key_in;
        end
        if (apply_fire) begin
            m_data_reg.success      <= op_ok;
            m_data_reg.refused_full <= ins_refused;
            m_data_reg.entry_count  <= count_wide[COUNT_OUT_BITS-1:0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SST_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `SST_ASSERT_NEXT(a_apply_done, apply_fire, state_reg == ST_IDLE && m_valid_reg, "apply step did not complete")
    `SST_ASSERT_IMPL(a_count_change, !$stable(count_reg), $past(apply_fire), "count changed outside apply step")
    `SST_ASSERT_IMPL(a_full_flag, m_valid_reg && m_data_reg.refused_full, is_full, "refused insert while not full")
    `SST_ASSERT_IMPL(a_shift_excl, apply_fire, !(ctrl.ins_en && ctrl.del_en), "insert and delete shift together")

endmodule
